@@ rtl/cle_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_pkg
// Request kinds, status codes and fixed field widths of the circular list
// engine.
// ----------------------------------------------------------------------------
package cle_pkg;

	localparam int VALUE_W = 32;
	localparam int POS_W   = 7;
	localparam int KIND_W  = 4;
	localparam int STAT_W  = 2;

	typedef enum logic [KIND_W-1:0] {
		K_INS_FIRST = 4'd0,
		K_INS_LAST  = 4'd1,
		K_DEL_FIRST = 4'd2,
		K_DEL_LAST  = 4'd3,
		K_INS_POS   = 4'd4,
		K_DEL_POS   = 4'd5,
		K_REVERSE   = 4'd6,
		K_COUNT     = 4'd7,
		K_READ      = 4'd8
	} kind_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_RANGE = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

endpackage

@@ rtl/circular_list_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_list_engine
// Bounded ordered list of signed 32-bit values kept as a circular linked
// store with a free list; one result word per request word.
// ----------------------------------------------------------------------------
// One request is worked at a time. Front inserts and deletes, back inserts
// and deletes, positional requests and reads walk the links from the head,
// one link per cycle through the link RAM's read port, walking at most as
// many links as the list is long; reverse walks to the tail and then
// rewrites every link. Count, failing requests and unused kinds go straight
// to the result. The next request is taken once the current one has reached
// the output register.
module circular_list_engine #(
	parameter int CAPACITY = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [cle_pkg::KIND_W-1:0]    kind,
	input  logic [cle_pkg::VALUE_W-1:0]   value_in,
	input  logic [cle_pkg::POS_W-1:0]     position,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [cle_pkg::STAT_W-1:0]    status,
	output logic [cle_pkg::VALUE_W-1:0]   value_out,
	output logic [cle_pkg::POS_W-1:0]     length
);

	import cle_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > POS_W) ? CW : POS_W;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_WALK = 6'b000010,
		S_W1   = 6'b000100,
		S_W2   = 6'b001000,
		S_REV  = 6'b010000,
		S_DONE = 6'b100000
	} state_t;

	typedef enum logic [2:0] {
		OP_INS_HEAD,
		OP_INS_AFTER,
		OP_DEL_HEAD,
		OP_DEL_AFTER,
		OP_REV,
		OP_READ
	} op_t;

	state_t              state_q;
	op_t                 op_q;
	logic                keep_q;
	logic [VALUE_W-1:0]  val_q;
	logic [CW-1:0]       cnt_q;
	logic                pend_q;
	logic [AW-1:0]       cur_q;
	logic [AW-1:0]       a_q;
	logic [AW-1:0]       b_q;
	logic [AW-1:0]       head_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       hw_q;
	status_t             res_status_q;
	logic [VALUE_W-1:0]  res_value_q;
	logic                out_valid_q;
	logic [STAT_W-1:0]   status_q;
	logic [VALUE_W-1:0]  value_q;
	logic [POS_W-1:0]    length_q;

	logic                link_we;
	logic [AW-1:0]       link_waddr, link_wdata, link_raddr, link_rdata;
	logic                elem_we;
	logic [VALUE_W-1:0]  elem_rdata;
	logic                fl_we;
	logic [AW-1:0]       fl_waddr, fl_rdata;

	logic [AW-1:0]       fs;
	logic                is_empty, is_full, is_one;
	logic [PW-1:0]       pos_w, n_w;
	logic [CW-1:0]       pos_c;
	logic                pos_gt_n, pos_ge_n, pos_zero;
	logic                ins_op;
	logic                load_out;

	// request decode helpers
	assign is_empty = (count_q == '0);
	assign is_one   = (count_q == CW'(1));
	assign is_full  = (count_q >= CW'(CAPACITY));
	assign pos_w    = PW'(position);
	assign n_w      = PW'(count_q);
	assign pos_gt_n = (pos_w > n_w);
	assign pos_ge_n = (pos_w >= n_w);
	assign pos_zero = (position == '0);
	assign pos_c    = CW'(pos_w);
	assign ins_op   = (op_q == OP_INS_HEAD) || (op_q == OP_INS_AFTER);

	// result moves into the output register
	assign load_out = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	// free slot: at or above the high-water mark the next slot is the count itself, else the free list
	assign fs = (count_q >= hw_q) ? count_q[AW-1:0] : fl_rdata;

	// link RAM port control
	always_comb begin
		link_raddr = cur_q;
		link_we    = 1'b0;
		link_waddr = cur_q;
		link_wdata = fs;
		unique case (state_q)
			S_WALK: begin
				if (pend_q) begin
					link_raddr = link_rdata;
				end
			end
			S_REV: begin
				if (pend_q && cnt_q != '0) begin
					link_raddr = link_rdata;
					link_we    = 1'b1;
					link_wdata = a_q;
				end
			end
			S_W1: begin
				if (ins_op) begin
					link_we    = 1'b1;
					link_waddr = is_empty ? fs : cur_q;
				end else begin
					link_raddr = b_q;
				end
			end
			S_W2: begin
				if (ins_op) begin
					link_we    = 1'b1;
					link_waddr = fs;
					link_wdata = b_q;
				end else if (!(op_q == OP_DEL_HEAD && is_one)) begin
					link_we    = 1'b1;
					link_wdata = link_rdata;
				end
			end
			default: begin
			end
		endcase
	end

	assign elem_we  = (state_q == S_W1) && ins_op;
	assign fl_we    = (state_q == S_W2) && !ins_op;
	assign fl_waddr = AW'(count_q - CW'(1));

	cle_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.raddr (link_raddr),
		.rdata (link_rdata)
	);

	cle_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_elem_ram (
		.clk   (clk),
		.we    (elem_we),
		.waddr (fs),
		.wdata (val_q),
		.raddr (cur_q),
		.rdata (elem_rdata)
	);

	cle_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_free_ram (
		.clk   (clk),
		.we    (fl_we),
		.waddr (fl_waddr),
		.wdata (b_q),
		.raddr (count_q[AW-1:0]),
		.rdata (fl_rdata)
	);

	// output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			hw_q        <= '0;
			pend_q      <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						val_q        <= value_in;
						res_status_q <= ST_OK;
						res_value_q  <= '0;
						cur_q        <= head_q;
						pend_q       <= 1'b0;
						b_q          <= head_q;
						keep_q       <= (kind == K_INS_LAST);
						state_q      <= S_DONE;
						unique case (kind)
							K_INS_FIRST, K_INS_LAST: begin
								if (is_full) begin
									res_status_q <= ST_FULL;
								end else begin
									op_q    <= OP_INS_HEAD;
									cnt_q   <= count_q - CW'(1);
									state_q <= is_empty ? S_W1 : S_WALK;
								end
							end
							K_DEL_FIRST: begin
								if (is_empty) begin
									res_status_q <= ST_EMPTY;
								end else begin
									op_q    <= OP_DEL_HEAD;
									cnt_q   <= count_q - CW'(1);
									state_q <= is_one ? S_W1 : S_WALK;
								end
							end
							K_DEL_LAST: begin
								if (is_empty) begin
									res_status_q <= ST_EMPTY;
								end else if (is_one) begin
									op_q    <= OP_DEL_HEAD;
									state_q <= S_W1;
								end else begin
									op_q    <= OP_DEL_AFTER;
									cnt_q   <= count_q - CW'(2);
									state_q <= S_WALK;
								end
							end
							K_INS_POS: begin
								if (is_empty) begin
									res_status_q <= ST_EMPTY;
								end else if (pos_gt_n) begin
									res_status_q <= ST_RANGE;
								end else if (is_full) begin
									res_status_q <= ST_FULL;
								end else if (pos_zero) begin
									op_q    <= OP_INS_HEAD;
									cnt_q   <= count_q - CW'(1);
									state_q <= S_WALK;
								end else begin
									op_q    <= OP_INS_AFTER;
									cnt_q   <= pos_c - CW'(1);
									state_q <= S_WALK;
								end
							end
							K_DEL_POS: begin
								if (is_empty) begin
									res_status_q <= ST_EMPTY;
								end else if (pos_ge_n) begin
									res_status_q <= ST_RANGE;
								end else if (pos_zero) begin
									op_q    <= OP_DEL_HEAD;
									cnt_q   <= count_q - CW'(1);
									state_q <= is_one ? S_W1 : S_WALK;
								end else begin
									op_q    <= OP_DEL_AFTER;
									cnt_q   <= pos_c - CW'(1);
									state_q <= S_WALK;
								end
							end
							K_REVERSE: begin
								if (is_empty) begin
									res_status_q <= ST_EMPTY;
								end else begin
									op_q    <= OP_REV;
									cnt_q   <= count_q - CW'(1);
									state_q <= S_WALK;
								end
							end
							K_COUNT: begin
								res_value_q <= VALUE_W'(count_q);
							end
							K_READ: begin
								if (is_empty) begin
									res_status_q <= ST_EMPTY;
								end else if (pos_ge_n) begin
									res_status_q <= ST_RANGE;
								end else begin
									op_q    <= OP_READ;
									cnt_q   <= pos_c;
									state_q <= S_WALK;
								end
							end
							default: begin
							end
						endcase
					end
				end

				// follow links from the head; exits with link[cur] on the read port
				S_WALK: begin
					if (pend_q && cnt_q == '0) begin
						unique case (op_q)
							OP_INS_AFTER, OP_DEL_AFTER: begin
								b_q     <= link_rdata;
								state_q <= S_W1;
							end
							OP_REV: begin
								a_q     <= cur_q;
								head_q  <= cur_q;
								cur_q   <= head_q;
								cnt_q   <= count_q;
								pend_q  <= 1'b0;
								state_q <= S_REV;
							end
							default: begin
								state_q <= S_W1;
							end
						endcase
					end else if (!pend_q) begin
						pend_q <= 1'b1;
					end else begin
						cur_q <= link_rdata;
						cnt_q <= cnt_q - CW'(1);
					end
				end

				// first write or read after the walk
				S_W1: begin
					if (op_q == OP_READ) begin
						res_value_q <= elem_rdata;
						state_q     <= S_DONE;
					end else begin
						if (op_q == OP_INS_HEAD) begin
							b_q <= is_empty ? fs : head_q;
						end
						state_q <= S_W2;
					end
				end

				// second link write, head and count update
				S_W2: begin
					if (ins_op) begin
						count_q <= count_q + CW'(1);
						if (op_q == OP_INS_HEAD && (!keep_q || is_empty)) begin
							head_q <= fs;
						end
					end else begin
						count_q <= count_q - CW'(1);
						if (count_q > hw_q) begin
							hw_q <= count_q;
						end
						if (op_q == OP_DEL_HEAD) begin
							head_q <= is_one ? '0 : link_rdata;
						end
					end
					state_q <= S_DONE;
				end

				// turn every link around, one per cycle
				S_REV: begin
					if (cnt_q == '0) begin
						state_q <= S_DONE;
					end else if (!pend_q) begin
						pend_q <= 1'b1;
					end else begin
						a_q   <= cur_q;
						cur_q <= link_rdata;
						cnt_q <= cnt_q - CW'(1);
					end
				end

				S_DONE: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (load_out) begin
			status_q <= res_status_q;
			value_q  <= res_value_q;
			length_q <= POS_W'(count_q);
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign value_out = value_q;
	assign length    = length_q;

	// element count stays within the store
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("element count above capacity");

	// an empty list always has its head at slot zero
	a_empty_head: assert property (@(posedge clk) disable iff (!arst_n)
		is_empty |-> head_q == '0)
		else $error("empty list with nonzero head");

	// count changes only when a request commits
	a_count_commit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_W2 |=> $stable(count_q))
		else $error("count changed outside commit");

	// a result is only loaded when the output register is free
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> out_valid_q)
		else $error("pending result dropped");

	// an accepted request leaves idle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> state_q != S_IDLE)
		else $error("accepted request not started");

endmodule

@@ rtl/cle_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data (old data on a same-address read and write).
// ----------------------------------------------------------------------------
module cle_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ sim/circular_list_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_list_checker
// Watches the request and result channels of the circular list engine, keeps
// a plain array model of the list and compares every result word with it.
// ----------------------------------------------------------------------------
module circular_list_checker #(
	parameter int CAPACITY = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  logic [cle_pkg::KIND_W-1:0]  kind,
	input  logic [cle_pkg::VALUE_W-1:0] value_in,
	input  logic [cle_pkg::POS_W-1:0]   position,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  logic [cle_pkg::STAT_W-1:0]  status,
	input  logic [cle_pkg::VALUE_W-1:0] value_out,
	input  logic [cle_pkg::POS_W-1:0]   length,
	output int                          fail_count,
	output int                          pending,
	output int                          result_count
);
	import cle_pkg::*;

	typedef struct packed {
		logic [STAT_W-1:0]  st;
		logic [VALUE_W-1:0] val;
		logic [POS_W-1:0]   len;
	} result_t;

	// list contents in order, front first
	logic [VALUE_W-1:0] list_q[$];
	result_t            answer_q[$];

	function automatic result_t apply_request(logic [KIND_W-1:0] k,
			logic [VALUE_W-1:0] v, logic [POS_W-1:0] p);
		result_t r;
		int n;
		logic [VALUE_W-1:0] tmp[$];
		n = list_q.size();
		r = '0;
		r.st = ST_OK;
		case (k)
			K_INS_FIRST, K_INS_LAST: begin
				if (n >= CAPACITY) r.st = ST_FULL;
				else if (k == K_INS_FIRST) list_q.push_front(v);
				else list_q.push_back(v);
			end
			K_DEL_FIRST: begin
				if (n == 0) r.st = ST_EMPTY;
				else void'(list_q.pop_front());
			end
			K_DEL_LAST: begin
				if (n == 0) r.st = ST_EMPTY;
				else void'(list_q.pop_back());
			end
			K_INS_POS: begin
				if (n == 0) r.st = ST_EMPTY;
				else if (p > n) r.st = ST_RANGE;
				else if (n >= CAPACITY) r.st = ST_FULL;
				else list_q.insert(p, v);
			end
			K_DEL_POS: begin
				if (n == 0) r.st = ST_EMPTY;
				else if (p >= n) r.st = ST_RANGE;
				else list_q.delete(p);
			end
			K_REVERSE: begin
				if (n == 0) r.st = ST_EMPTY;
				else begin
					foreach (list_q[i]) tmp.push_front(list_q[i]);
					list_q = tmp;
				end
			end
			K_COUNT: r.val = VALUE_W'(n);
			K_READ: begin
				if (n == 0) r.st = ST_EMPTY;
				else if (p >= n) r.st = ST_RANGE;
				else r.val = list_q[p];
			end
			default: ;
		endcase
		r.len = POS_W'(list_q.size());
		return r;
	endfunction

	// predict on accepted requests, compare on accepted results
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			list_q.delete();
			answer_q.delete();
			fail_count <= 0;
			result_count <= 0;
			pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				result_count <= result_count + 1;
				if (answer_q.size() == 0) begin
					$error("result word with no request waiting");
					fail_count <= fail_count + 1;
				end else begin
					want = answer_q.pop_front();
					if (status !== want.st || value_out !== want.val
							|| length !== want.len) begin
						if (status !== want.st)
							$error("status: expected %0d, got %0d", want.st, status);
						if (value_out !== want.val)
							$error("value_out: expected %0d, got %0d",
								$signed(want.val), $signed(value_out));
						if (length !== want.len)
							$error("length: expected %0d, got %0d", want.len, length);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (in_valid && !in_stall)
				answer_q.push_back(apply_request(kind, value_in, position));
			pending <= answer_q.size();
		end
	end
endmodule

@@ sim/tb_circular_list_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_circular_list_engine
// Drives directed and random request words into the circular list engine
// with random gaps and result back-pressure; the checker does the comparing.
// ----------------------------------------------------------------------------
module tb_circular_list_engine;
	import cle_pkg::*;

	localparam int CAPACITY = 64;
	localparam int N_RANDOM = 1760;
	localparam int CYCLE_LIMIT = 1500000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [KIND_W-1:0] kind = '0;
	logic [VALUE_W-1:0] value_in = '0;
	logic [POS_W-1:0] position = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [STAT_W-1:0] status;
	logic [VALUE_W-1:0] value_out;
	logic [POS_W-1:0] length;
	int fail_count, pending, result_count;
	int cycle_no = 0;
	int sent = 0;
	bit calm = 1'b0;   // no idling on either side
	bit hold = 1'b0;   // long receiver hold-off
	int list_len = 0;  // rough length tracking to steer random kinds

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	circular_list_engine #(.CAPACITY(CAPACITY)) dut (.*);

	circular_list_checker #(.CAPACITY(CAPACITY)) chk (.*);

	// cycle limit
	always @(posedge clk) begin
		cycle_no <= cycle_no + 1;
		if (cycle_no > CYCLE_LIMIT) begin
			$display("tb_circular_list_engine: done, errors");
			$finish;
		end
	end

	// receiver side stall
	always @(posedge clk) begin
		if (hold) out_stall <= 1'b1;
		else out_stall <= calm ? 1'b0 : ($urandom_range(99) < 32);
	end

	// hand one request word over and wait for acceptance
	task automatic send_word(logic [KIND_W-1:0] k, logic [VALUE_W-1:0] v,
			logic [POS_W-1:0] p);
		while (!calm && $urandom_range(99) < 32) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		value_in <= v;
		position <= p;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent++;
		case (k)
			K_INS_FIRST, K_INS_LAST, K_INS_POS:
				if (list_len < CAPACITY && !(k == K_INS_POS && list_len == 0))
					list_len++;
			K_DEL_FIRST, K_DEL_LAST, K_DEL_POS: if (list_len > 0) list_len--;
			default: ;
		endcase
	endtask

	function automatic logic [VALUE_W-1:0] rand_value();
		case ($urandom_range(3))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		logic [KIND_W-1:0] k;
		logic [POS_W-1:0] p;
		int r;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty-list cases, then the extremes of the value field, range errors and unused kinds
		send_word(K_DEL_FIRST, '0, '0);
		send_word(K_DEL_LAST, '0, '0);
		send_word(K_DEL_POS, '0, '0);
		send_word(K_REVERSE, '0, '0);
		send_word(K_READ, '0, '0);
		send_word(K_INS_POS, 32'h1234, '0);
		send_word(K_COUNT, '0, '0);
		send_word(K_INS_FIRST, 32'h8000_0000, '0);
		send_word(K_INS_LAST, 32'h7fff_ffff, '0);
		send_word(K_INS_POS, 32'hffff_ffff, 7'd1);
		send_word(K_INS_POS, 32'h5, 7'd4);
		send_word(K_INS_POS, 32'h6, 7'd3);
		send_word(K_READ, '0, 7'd2);
		send_word(K_READ, '0, 7'h7f);
		send_word(K_DEL_POS, '0, 7'd4);
		send_word(K_REVERSE, '0, '0);
		send_word(K_READ, '0, '0);
		send_word(K_DEL_LAST, '0, '0);
		send_word(K_DEL_POS, '0, 7'd1);
		send_word(4'hf, 32'hffff_ffff, 7'h7f);
		send_word(4'd9, '0, '0);
		send_word(K_COUNT, '0, '0);

		// fill to capacity while the receiver holds off, then overflow
		fork
			begin
				hold = 1'b1;
				repeat (400) @(posedge clk);
				hold = 1'b0;
			end
			while (list_len < CAPACITY) send_word(K_INS_LAST, $urandom, '0);
		join
		send_word(K_INS_FIRST, 32'h1, '0);
		send_word(K_INS_POS, 32'h1, 7'd64);
		send_word(K_INS_POS, 32'h1, 7'd65);
		send_word(K_READ, '0, 7'd63);
		send_word(K_REVERSE, '0, '0);

		// random phase; bias toward keeping the list mid-sized
		for (int i = 0; i < N_RANDOM; i++) begin
			calm = (i >= 600 && i < 800);
			r = $urandom_range(99);
			if (r < 3) k = KIND_W'($urandom_range(15));
			else if (r < 30)
				k = (list_len < 40) ? KIND_W'($urandom_range(1)) : KIND_W'($urandom_range(2, 3));
			else k = KIND_W'($urandom_range(8));
			case ($urandom_range(9))
				0: p = POS_W'($urandom);
				1: p = POS_W'(list_len);
				default: p = POS_W'($urandom_range(list_len > 0 ? list_len - 1 : 0));
			endcase
			send_word(k, rand_value(), p);
		end
		in_valid <= 1'b0;
		calm = 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("covered %0d request words and %0d result words, incl. full and empty list",
			sent, result_count);
		if (fail_count == 0)
			$display("tb_circular_list_engine: done, clean");
		else
			$display("tb_circular_list_engine: done, errors");
		$finish;
	end
endmodule
